// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int REQ_W   = 13;
    localparam int FADDR_W = 12;
    localparam int ADDR_W  = 12;
    localparam int USIZE_W = 13;
    localparam int STAT_W  = 2;
    localparam int HDR_W   = 7;
    localparam int PORD_W  = 4;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 1;
    localparam int TDATA_W = 32;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_BLOCK = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO     = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd3;

    localparam logic [IDX_W-1:0] REG_POOL_ORDER   = 1'd0;
    localparam logic [IDX_W-1:0] REG_HEADER_BYTES = 1'd1;

    localparam logic ACT_ALLOC = 1'b0;

    // free map access kinds
    localparam logic [1:0] MK_CLR  = 2'd0;
    localparam logic [1:0] MK_SRCH = 2'd1;
    localparam logic [1:0] MK_SPL  = 2'd2;
    localparam logic [1:0] MK_MRG  = 2'd3;

    typedef struct packed {
        logic              load;
        logic              clr_init;
        logic              clr_step;
        logic              rd;
        logic              wr;
        logic [1:0]        acc;
        logic              srch_init;
        logic              srch_adv;
        logic              take;
        logic              spl_adv;
        logic              ord_take;
        logic              mrg_adv;
        logic              set_err;
        logic [STAT_W-1:0] err_code;
        logic              set_ok_alloc;
        logic              set_ok_free;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic              is_free;
        logic [STAT_W-1:0] chk_err;
        logic              hit;
        logic              last_row;
        logic              last_ord;
        logic              at_tgt;
        logic              buddy;
        logic              clr_last;
    } t_sts;

endpackage

// ===== src/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clear pass, checks, search, split and merge.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  logic i_pool_we,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CINIT = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_SRD   = 4'd4;
    localparam logic [3:0] S_SCHK  = 4'd5;
    localparam logic [3:0] S_SPRD  = 4'd6;
    localparam logic [3:0] S_SPWR  = 4'd7;
    localparam logic [3:0] S_ORDW  = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_MWR   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    t_cmd       cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CINIT: begin
                cmd.clr_init = 1'b1;
                n_state      = S_CLR;
            end
            S_CLR: begin
                cmd.wr       = 1'b1;
                cmd.acc      = MK_CLR;
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.chk_err != STATUS_OK) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = i_sts.chk_err;
                    n_state      = S_DONE;
                end else if (!i_sts.is_free) begin
                    cmd.srch_init = 1'b1;
                    n_state       = S_SRD;
                end else begin
                    n_state = S_ORDW;
                end
            end
            S_SRD: begin
                cmd.rd  = 1'b1;
                cmd.acc = MK_SRCH;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (i_sts.hit) begin
                    cmd.take = 1'b1;
                    n_state  = S_SPRD;
                end else if (i_sts.last_row && i_sts.last_ord) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = STATUS_NO_BLOCK;
                    n_state      = S_DONE;
                end else begin
                    cmd.srch_adv = 1'b1;
                    n_state      = S_SRD;
                end
            end
            S_SPRD: begin
                cmd.rd  = 1'b1;
                cmd.acc = MK_SPL;
                n_state = S_SPWR;
            end
            S_SPWR: begin
                cmd.wr  = 1'b1;
                cmd.acc = MK_SPL;
                if (i_sts.at_tgt) begin
                    cmd.set_ok_alloc = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    cmd.spl_adv = 1'b1;
                    n_state     = S_SPRD;
                end
            end
            S_ORDW: begin
                cmd.ord_take = 1'b1;
                n_state      = S_MRD;
            end
            S_MRD: begin
                cmd.rd  = 1'b1;
                cmd.acc = MK_MRG;
                n_state = S_MWR;
            end
            S_MWR: begin
                cmd.wr  = 1'b1;
                cmd.acc = MK_MRG;
                if (i_sts.buddy) begin
                    cmd.mrg_adv = 1'b1;
                    n_state     = S_MRD;
                end else begin
                    cmd.set_ok_free = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CINIT;
        endcase
        // pool reinit after a pool order write
        if (i_pool_we) n_state = S_CINIT;
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.out_load)     n_ovalid = 1'b1;
        else if (i_out_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CINIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== src/bba_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: config registers, free map rows, slot tables, result.
// ----------------------------------------------------------------------------
module bba_dp import bba_pkg::*; #(
    parameter int MAX_POOL_ORDER  = 12,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_action,
    input  logic [REQ_W-1:0]   i_req_size,
    input  logic [FADDR_W-1:0] i_free_addr,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [STAT_W-1:0]  o_status,
    output logic [ADDR_W-1:0]  o_addr,
    output logic [USIZE_W-1:0] o_usable_size
);

    localparam int MO    = $clog2(MIN_BLOCK_BYTES);
    localparam int AW    = MAX_POOL_ORDER;
    localparam int OW    = $clog2(MAX_POOL_ORDER + 1);
    localparam int NB    = MAX_POOL_ORDER - MO + 1;
    localparam int NN    = 2 ** NB;
    localparam int W     = (NN < 32) ? NN : 32;
    localparam int LW    = $clog2(W);
    localparam int R     = NN / W;
    localparam int RB    = (R > 1) ? $clog2(R) : 1;
    localparam int SB    = MAX_POOL_ORDER - MO;
    localparam int SBW   = (SB > 0) ? SB : 1;
    localparam int SLOTS = 2 ** SB;
    localparam int NEEDW = REQ_W + 1;
    localparam int CW    = (AW + 1 > NEEDW) ? AW + 1 : NEEDW;
    localparam int POOL_RST = (11 < MO) ? MO : ((11 > MAX_POOL_ORDER) ? MAX_POOL_ORDER : 11);

    logic [OW-1:0]      r_pool;
    logic [HDR_W-1:0]   r_hdr;
    logic               r_act;
    logic [REQ_W-1:0]   r_size;
    logic [FADDR_W-1:0] r_faddr;
    logic [RB-1:0]      r_row;
    logic [OW-1:0]      r_i, r_tgt;
    logic [NB-1:0]      r_n, r_p;
    logic               r_pv;
    logic [AW-1:0]      r_off;
    logic [W-1:0]       r_rdata;
    logic [W-1:0]       r_map [R];
    logic [OW-1:0]      r_ord [SLOTS];
    logic [OW-1:0]      r_ord_rd;
    logic [SLOTS-1:0]   r_valid;
    logic [STAT_W-1:0]  r_st;
    logic [ADDR_W-1:0]  r_ra;
    logic [USIZE_W-1:0] r_rs;

    function automatic logic [NB-1:0] node_of(input logic [OW-1:0] o, input logic [AW-1:0] off);
        logic [AW:0] v;
        v = ((AW + 1)'(1) << (MAX_POOL_ORDER - int'(o))) + ((AW + 1)'(off) >> o);
        return v[NB-1:0];
    endfunction

    function automatic logic [RB-1:0] row_of(input logic [NB-1:0] n);
        return RB'(n >> LW);
    endfunction

    function automatic logic [NB-1:0] base_of(input logic [OW-1:0] o);
        return NB'((NB + 1)'(1) << (MAX_POOL_ORDER - int'(o)));
    endfunction

    // allocate sizing
    logic [NEEDW-1:0] need, need_m1;
    logic [4:0]       bl;
    logic [OW-1:0]    o_need;
    logic [CW-1:0]    pool_bytes;
    logic             too_big;

    always_comb begin
        need    = NEEDW'(r_size) + NEEDW'(r_hdr);
        need_m1 = need - NEEDW'(1);
        bl      = '0;
        for (int k = 0; k < NEEDW; k++) begin
            if (need_m1[k]) bl = 5'(k + 1);
        end
        o_need     = (int'(bl) < MO) ? OW'(MO) : OW'(bl);
        pool_bytes = CW'(1) << r_pool;
        too_big    = CW'(need) > pool_bytes;
    end

    // free checks
    logic [CW-1:0]  offw;
    logic [AW-1:0]  off_f;
    logic [SBW-1:0] slot_f, slot_a;
    logic           bad_free;
    logic [OW-1:0]  o_clamp;

    always_comb begin
        offw     = CW'(r_faddr) - CW'(r_hdr);
        off_f    = AW'(offw);
        slot_f   = SBW'(off_f >> MO);
        slot_a   = SBW'(r_off >> MO);
        bad_free = (r_faddr < FADDR_W'(r_hdr)) || (offw[MO-1:0] != '0) ||
                   (offw >= pool_bytes) || !r_valid[slot_f];
        o_clamp  = r_ord_rd;
        if (int'(r_ord_rd) < MO) o_clamp = OW'(MO);
        if (r_ord_rd > r_pool)   o_clamp = r_pool;
    end

    // row search
    logic [W-1:0]  mask, hits;
    logic [LW-1:0] pri;
    logic [NB:0]   nd;
    logic [NB-1:0] n_found, base_i, root;
    logic [RB-1:0] row_end;

    always_comb begin
        base_i = base_of(r_i);
        for (int b = 0; b < W; b++) begin
            nd      = ((NB + 1)'(r_row) << LW) | (NB + 1)'(b);
            mask[b] = (nd >> (MAX_POOL_ORDER - int'(r_i))) == (NB + 1)'(1);
        end
        hits = r_rdata & mask;
        pri  = '0;
        for (int b = W - 1; b >= 0; b--) begin
            if (hits[b]) pri = LW'(b);
        end
        n_found = NB'(((NB + 1)'(r_row) << LW) | (NB + 1)'(pri));
        row_end = row_of(NB'(((NB + 1)'(base_i) << 1) - (NB + 1)'(1)));
        root    = base_of(r_pool);
    end

    // free map port
    logic [RB-1:0] maddr;
    logic [W-1:0]  wdata;
    logic [NB-1:0] bud;

    always_comb begin
        bud = r_n ^ NB'(1);
        case (i_cmd.acc)
            MK_SPL:  maddr = row_of(r_p);
            MK_MRG:  maddr = row_of(r_n);
            default: maddr = r_row;
        endcase
        case (i_cmd.acc)
            MK_CLR: begin
                wdata = '0;
                if (r_row == row_of(root)) wdata = W'(1) << root[LW-1:0];
            end
            MK_SPL: begin
                if (r_pv) wdata = r_rdata | (W'(1) << r_p[LW-1:0]);
                else      wdata = r_rdata & ~(W'(1) << r_p[LW-1:0]);
            end
            MK_MRG: begin
                if (o_sts.buddy) wdata = r_rdata & ~(W'(1) << bud[LW-1:0]);
                else             wdata = r_rdata | (W'(1) << r_n[LW-1:0]);
            end
            default: wdata = r_rdata;
        endcase
    end

    always_comb begin
        o_sts          = '0;
        o_sts.is_free  = (r_act != ACT_ALLOC);
        if (r_act == ACT_ALLOC) begin
            if (r_size == '0)  o_sts.chk_err = STATUS_ZERO;
            else if (too_big)  o_sts.chk_err = STATUS_NO_BLOCK;
        end else if (bad_free) begin
            o_sts.chk_err = STATUS_BAD_FREE;
        end
        o_sts.hit      = (hits != '0);
        o_sts.last_row = (r_row == row_end);
        o_sts.last_ord = (r_i == r_pool);
        o_sts.at_tgt   = (r_i == r_tgt);
        o_sts.buddy    = (r_i < r_pool) && r_rdata[bud[LW-1:0]];
        o_sts.clr_last = (r_row == RB'(R - 1));
    end

    logic [CW-1:0] usz;
    always_comb begin
        if (i_cmd.set_ok_alloc) usz = (CW'(1) << r_tgt) - CW'(r_hdr);
        else                    usz = (CW'(1) << r_i) - CW'(r_hdr);
    end

    // config registers and slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool  <= OW'(POOL_RST);
            r_hdr   <= HDR_W'(40);
            r_valid <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_POOL_ORDER) begin
                if (int'(i_cfg_data[PORD_W-1:0]) < MO)
                    r_pool <= OW'(MO);
                else if (int'(i_cfg_data[PORD_W-1:0]) > MAX_POOL_ORDER)
                    r_pool <= OW'(MAX_POOL_ORDER);
                else
                    r_pool <= OW'(i_cfg_data[PORD_W-1:0]);
                r_valid <= '0;
            end else begin
                if (i_cmd.set_ok_alloc) r_valid[slot_a] <= 1'b1;
                if (i_cmd.ord_take)     r_valid[slot_f] <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == REG_HEADER_BYTES) r_hdr <= i_cfg_data[HDR_W-1:0];
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= r_map[maddr];
        if (i_cmd.wr) r_map[maddr] <= wdata;
        r_ord_rd <= r_ord[slot_f];
        if (i_cmd.set_ok_alloc) r_ord[slot_a] <= r_tgt;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            if (i_cmd.clr_init) r_row <= '0;
            if (i_cmd.clr_step) r_row <= r_row + RB'(1);
            if (i_cmd.srch_init) r_row <= row_of(base_of(o_need));
            if (i_cmd.srch_adv) begin
                if (o_sts.last_row) r_row <= row_of(base_of(r_i + OW'(1)));
                else                r_row <= r_row + RB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_size  <= i_req_size;
            r_faddr <= i_free_addr;
        end
        if (i_cmd.srch_init) begin
            r_i   <= o_need;
            r_tgt <= o_need;
        end
        if (i_cmd.srch_adv && o_sts.last_row) r_i <= r_i + OW'(1);
        if (i_cmd.take) begin
            r_n   <= n_found;
            r_p   <= n_found;
            r_pv  <= 1'b0;
            r_off <= AW'((CW'(n_found - base_i)) << r_i);
        end
        if (i_cmd.spl_adv) begin
            r_n  <= r_n << 1;
            r_p  <= (r_n << 1) | NB'(1);
            r_pv <= 1'b1;
            r_i  <= r_i - OW'(1);
        end
        if (i_cmd.ord_take) begin
            r_i <= o_clamp;
            r_n <= node_of(o_clamp, off_f);
        end
        if (i_cmd.mrg_adv) begin
            r_n <= r_n >> 1;
            r_i <= r_i + OW'(1);
        end
        if (i_cmd.set_err) begin
            r_st <= i_cmd.err_code;
            r_ra <= '0;
            r_rs <= '0;
        end
        if (i_cmd.set_ok_alloc) begin
            r_st <= STATUS_OK;
            r_ra <= ADDR_W'(CW'(r_off) + CW'(r_hdr));
            r_rs <= USIZE_W'(usz);
        end
        if (i_cmd.set_ok_free) begin
            r_st <= STATUS_OK;
            r_ra <= ADDR_W'(r_faddr);
            r_rs <= USIZE_W'(usz);
        end
        if (i_cmd.out_load) begin
            o_status      <= r_st;
            o_addr        <= r_ra;
            o_usable_size <= r_rs;
        end
    end

endmodule

// ===== src/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator: allocate a byte count or free a user offset.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer when          | payload
//  s_axis   | in  | tvalid & tready        | tuser: action; tdata: req_size, free_addr
//  m_axis   | out | tvalid & tready        | tuser: status; tdata: addr, usable_size
//  cfg      | in  | i_cfg_we               | index 0 pool_order, 1 header_bytes
//
//  Allocate: a check step, a read and a test per free map row scanned, a read
//  and a write per split level, then the result step. Free: a check step, an
//  order lookup, a read and a write per merge level, then the result step. The
//  single free map port splits every row read-modify-write into a read and a write.
//  Reset and every pool_order write start a clearing pass of NN/W rows (a setup
//  step plus 16 rows for the defaults) with s_axis tready low.
//  A finished result waits in the output register while the next transfer
//  is taken; a stalled m_axis only holds the block in its final step.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; #(
    parameter int MAX_POOL_ORDER  = 12,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // req_size[12:0], free_addr[24:13]
    input  logic [0:0]         i_s_axis_tuser,   // action[0]
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // addr[11:0], usable_size[24:12]
    output logic [STAT_W-1:0]  o_m_axis_tuser,   // status[1:0]
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    t_cmd               cmd;
    t_sts               sts;
    logic [ADDR_W-1:0]  addr;
    logic [USIZE_W-1:0] usable_size;

    // pool order writes restart the clearing pass
    logic pool_we;
    assign pool_we = i_cfg_we && (i_cfg_index == REG_POOL_ORDER);

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_pool_we   (pool_we),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bba_dp #(
        .MAX_POOL_ORDER  (MAX_POOL_ORDER),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_s_axis_tuser[0]),
        .i_req_size    (i_s_axis_tdata[REQ_W-1:0]),
        .i_free_addr   (i_s_axis_tdata[REQ_W+FADDR_W-1:REQ_W]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_m_axis_tuser),
        .o_addr        (addr),
        .o_usable_size (usable_size)
    );

    assign o_m_axis_tdata = {{(TDATA_W - ADDR_W - USIZE_W){1'b0}}, usable_size, addr};

endmodule
